FILE: hw/rtl/tnfs_pkg.sv
package tnfs_pkg;

  localparam int MAX_TOP = 16;
  localparam int FREQ_W  = 24;
  localparam int TAG_W   = 16;
  localparam int LEN_W   = 5;
  localparam int RANK_W  = 4;
  localparam int CNT_W   = $clog2(MAX_TOP + 1);

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(10);

  typedef struct packed {
    logic              valid;
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic load;    // insert beat taken this cycle
    logic active;  // cell lies inside the current list length
    logic pop;     // shift toward rank 0 during emission
    logic clear;   // empty the list after the final result
  } cell_ctl_t;

endpackage

FILE: hw/rtl/top_n_frequency_select.sv
// Streaming top-N selector. Each input beat carries a count and a word tag and is
// inserted into a descending list held in a row of cells, ahead of the first slot
// that is empty or holds a strictly lower count, so earlier beats win ties. A
// new input beat can be taken every cycle while the list is building. After the
// beat marked last_item, the list of list_length slots (0 reads as 1, values
// above 16 read as 16) shifts out one result per cycle while the output is not
// stalled, through the output register, rank 0 first, and input is held off
// until the final result has been loaded into the output register. The list is
// empty again when the result with last_result is presented. Unfilled slots come
// out with slot_valid low and zero count and tag. The user must write list_length
// through the cfg channel only while the block is idle; the block does not enforce this.
module top_n_frequency_select (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tnfs_pkg::LEN_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tnfs_pkg::FREQ_W-1:0] freq,
  input  logic [tnfs_pkg::TAG_W-1:0] word_tag,
  input  logic                       last_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tnfs_pkg::RANK_W-1:0] rank,
  output logic [tnfs_pkg::FREQ_W-1:0] out_freq,
  output logic [tnfs_pkg::TAG_W-1:0] out_tag,
  output logic                       slot_valid,
  output logic                       last_result
);
  import tnfs_pkg::*;

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  state_t           state;
  logic [LEN_W-1:0] list_length;
  logic [CNT_W-1:0] act_len;
  logic [CNT_W-1:0] emit_len;
  logic [CNT_W-1:0] emit_cnt;
  logic             in_beat;
  logic             out_load;
  logic             emit_last;
  entry_t           new_entry;
  entry_t           cells [MAX_TOP];
  logic [MAX_TOP:0] hit;
  cell_ctl_t        ctl [MAX_TOP];

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_beat   = in_valid && in_ready;
  assign out_load  = (state == ST_EMIT) && (!out_valid || out_ready);
  assign emit_last = (emit_cnt == emit_len - CNT_W'(1));

  assign new_entry.valid = 1'b1;
  assign new_entry.freq  = freq;
  assign new_entry.tag   = word_tag;

  always_comb begin
    if (list_length == '0) begin
      act_len = CNT_W'(1);
    end else if (int'(list_length) > MAX_TOP) begin
      act_len = CNT_W'(MAX_TOP);
    end else begin
      act_len = CNT_W'(list_length);
    end
  end

  assign hit[0] = 1'b0;

  for (genvar k = 0; k < MAX_TOP; k++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;

    if (k == 0) begin : g_first
      assign prev_e = new_entry;
    end else begin : g_mid
      assign prev_e = cells[k-1];
    end

    if (k == MAX_TOP - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = cells[k+1];
    end

    assign ctl[k].load   = in_beat;
    assign ctl[k].active = (CNT_W'(k) < act_len);
    assign ctl[k].pop    = out_load;
    assign ctl[k].clear  = out_load && emit_last;

    tnfs_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[k]),
      .new_entry  (new_entry),
      .hit_in     (hit[k]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (cells[k]),
      .hit_out    (hit[k+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      list_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      emit_cnt  <= '0;
      emit_len  <= CNT_W'(1);
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
          end
          if (in_beat && last_item) begin
            state    <= ST_EMIT;
            emit_cnt <= '0;
            emit_len <= act_len;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            // Rank 0 always sits in the first cell; the row shifts up behind it.
            out_valid   <= 1'b1;
            rank        <= RANK_W'(emit_cnt);
            slot_valid  <= cells[0].valid;
            out_freq    <= cells[0].valid ? cells[0].freq : '0;
            out_tag     <= cells[0].valid ? cells[0].tag : '0;
            last_result <= emit_last;
            emit_cnt    <= emit_cnt + CNT_W'(1);
            if (emit_last) begin
              state <= ST_IDLE;
            end
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_last) |=> (state == ST_IDLE) && out_valid && last_result)
    else $error("final result did not end the emission run");

  a_list_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_load && emit_last) |=> !cells[0].valid)
    else $error("list not cleared after emission");

  a_last_starts_emit: assert property (@(posedge clk) disable iff (rst)
    (in_beat && last_item) |=> (state == ST_EMIT) && (emit_cnt == '0))
    else $error("last input beat did not start emission");

  a_rank_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_cnt < emit_len))
    else $error("emission count ran past the list length");

endmodule

FILE: hw/rtl/tnfs_cell.sv
module tnfs_cell (
  input  logic               clk,
  input  logic               rst,
  input  tnfs_pkg::cell_ctl_t ctl,
  input  tnfs_pkg::entry_t   new_entry,
  input  logic               hit_in,
  input  tnfs_pkg::entry_t   prev_entry,
  input  tnfs_pkg::entry_t   next_entry,
  output tnfs_pkg::entry_t   entry,
  output logic               hit_out
);
  import tnfs_pkg::*;

  logic beats;
  logic take;

  // An empty slot loses to anything; a filled one only to a strictly higher count.
  assign beats   = ctl.active && (!entry.valid || (new_entry.freq > entry.freq));
  assign take    = beats && !hit_in;
  assign hit_out = hit_in || beats;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (ctl.clear) begin
      entry.valid <= 1'b0;
    end else if (ctl.load && ctl.active) begin
      if (take) begin
        entry <= new_entry;
      end else if (hit_in) begin
        entry <= prev_entry;
      end
    end else if (ctl.pop) begin
      entry <= next_entry;
    end
  end

endmodule

FILE: tb/sv/top_n_frequency_select_test.sv
module top_n_frequency_select_test;
  import tnfs_pkg::*;

  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 280;

  typedef enum logic {ROW_ITEM, ROW_LEN} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [FREQ_W-1:0] value;     // count of an item, or the new list length
    logic [TAG_W-1:0]  tag;
    logic              last;
    logic              typed;     // rank 0 of this run is given below
    logic [FREQ_W-1:0] top_freq;
    logic [TAG_W-1:0]  top_tag;
  } plan_row_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [FREQ_W-1:0] freq;
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic              last;
  } ranked_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [FREQ_W-1:0] freq = '0;
  logic [TAG_W-1:0]  word_tag = '0;
  logic              last_item = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RANK_W-1:0] rank;
  logic [FREQ_W-1:0] out_freq;
  logic [TAG_W-1:0]  out_tag;
  logic              slot_valid;
  logic              last_result;

  // Typed rank 0 expectation that travels with the beat on offer.
  logic              pend_typed = 1'b0;
  logic [FREQ_W-1:0] pend_top_freq = '0;
  logic [TAG_W-1:0]  pend_top_tag = '0;

  logic [FREQ_W-1:0] rank_freq [MAX_TOP];
  logic [TAG_W-1:0]  rank_tag [MAX_TOP];
  logic              rank_filled [MAX_TOP];
  logic [LEN_W-1:0]  list_len;
  ranked_t           due_ranks [$];
  int                errors = 0;
  bit                steady = 1'b0;
  bit                hold_req = 1'b0;

  top_n_frequency_select i_dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_ready, .freq, .word_tag, .last_item,
    .out_valid, .out_ready, .rank, .out_freq, .out_tag, .slot_valid, .last_result
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic clear_ranks();
    for (int s = 0; s < MAX_TOP; s++) begin
      rank_freq[s]   = '0;
      rank_tag[s]    = '0;
      rank_filled[s] = 1'b0;
    end
  endtask

  task automatic insert_entry(input logic [FREQ_W-1:0] f, input logic [TAG_W-1:0] t,
                              input logic last);
    int n;
    int k;
    ranked_t r;
    n = (list_len == 0) ? 1 : (list_len > MAX_TOP) ? MAX_TOP : int'(list_len);
    for (k = 0; k < n; k++)
      if (!rank_filled[k] || f > rank_freq[k]) break;
    if (k < n) begin
      for (int j = n - 1; j > k; j--) begin
        rank_freq[j]   = rank_freq[j-1];
        rank_tag[j]    = rank_tag[j-1];
        rank_filled[j] = rank_filled[j-1];
      end
      rank_freq[k]   = f;
      rank_tag[k]    = t;
      rank_filled[k] = 1'b1;
    end
    if (last) begin
      for (k = 0; k < n; k++) begin
        r.rank  = RANK_W'(k);
        r.freq  = rank_filled[k] ? rank_freq[k] : '0;
        r.tag   = rank_filled[k] ? rank_tag[k] : '0;
        r.valid = rank_filled[k];
        r.last  = (k == n - 1);
        if (k == 0 && pend_typed) begin
          r.freq  = pend_top_freq;
          r.tag   = pend_top_tag;
          r.valid = 1'b1;
        end
        due_ranks.push_back(r);
      end
      clear_ranks();
    end
  endtask

  // Results are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin : check_results
    ranked_t want;
    if (rst) begin
      clear_ranks();
      list_len = LEN_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (due_ranks.size() == 0) begin
          $error("result beat at rank %0d arrived with nothing expected", rank);
          errors++;
        end else begin
          want = due_ranks.pop_front();
          if (rank !== want.rank) begin
            $error("rank: expected %0d, got %0d", want.rank, rank);
            errors++;
          end
          if (out_freq !== want.freq) begin
            $error("out_freq: expected %0d, got %0d", want.freq, out_freq);
            errors++;
          end
          if (out_tag !== want.tag) begin
            $error("out_tag: expected 0x%04h, got 0x%04h", want.tag, out_tag);
            errors++;
          end
          if (slot_valid !== want.valid) begin
            $error("slot_valid: expected %0b, got %0b", want.valid, slot_valid);
            errors++;
          end
          if (last_result !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, last_result);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) insert_entry(freq, word_tag, last_item);
      if (cfg_valid && cfg_ready) list_len = cfg_data;
    end
  end

  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 16);
      end
    end
  end

  task automatic offer(input logic [FREQ_W-1:0] f, input logic [TAG_W-1:0] t,
                       input logic last, input logic typed,
                       input logic [FREQ_W-1:0] tf, input logic [TAG_W-1:0] tt);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    freq          <= f;
    word_tag      <= t;
    last_item     <= last;
    pend_typed    <= typed;
    pend_top_freq <= tf;
    pend_top_tag  <= tt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Non-last beats produce nothing, so after the last expected result the block
  // is given an extra drain period before it is treated as idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_ranks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_len(input logic [LEN_W-1:0] len);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    plan_row_t         plan [$];
    logic [FREQ_W-1:0] f;
    logic [LEN_W-1:0]  len;
    int                sent;
    int                run;
    int                run_items;
    plan = '{
      // Reset length; a zero count still beats an empty slot.
      '{ROW_ITEM, 24'd0, 16'h0001, 1'b1, 1'b1, 24'd0, 16'h0001},
      '{ROW_ITEM, 24'hFFFFFF, 16'hFFFF, 1'b1, 1'b1, 24'hFFFFFF, 16'hFFFF},
      // One slot: a tie and a lower count are both dropped.
      '{ROW_LEN, 24'd1, 16'h0000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd5, 16'h00A0, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd5, 16'h00A1, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd4, 16'h00A2, 1'b1, 1'b1, 24'd5, 16'h00A0},
      // Length zero acts as one.
      '{ROW_LEN, 24'd0, 16'h0000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd7, 16'h0B00, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd8, 16'h0B01, 1'b1, 1'b1, 24'd8, 16'h0B01},
      // Length above the maximum acts as the maximum.
      '{ROW_LEN, 24'd31, 16'h0000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd3, 16'h0C00, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd9, 16'h0C01, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd3, 16'h0C02, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd0, 16'h0C03, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd12, 16'h0C04, 1'b1, 1'b1, 24'd12, 16'h0C04},
      // Shrink mid-run: slots past the new length keep stale entries,
      // which show up again once the length grows back.
      '{ROW_LEN, 24'd16, 16'h0000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd50, 16'h1000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd40, 16'h1001, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd30, 16'h1002, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd20, 16'h1003, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd10, 16'h1004, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_LEN, 24'd2, 16'h0000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd60, 16'h1005, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_LEN, 24'd17, 16'h0000, 1'b0, 1'b0, 24'd0, 16'h0000},
      '{ROW_ITEM, 24'd0, 16'hFFFF, 1'b1, 1'b0, 24'd0, 16'h0000}
    };

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LEN)
        write_len(LEN_W'(plan[i].value));
      else
        offer(plan[i].value, plan[i].tag, plan[i].last, plan[i].typed,
              plan[i].top_freq, plan[i].top_tag);
    end

    sent = 0;
    run  = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = (run >= 8 && run < 12);
      // The receiver stalls while this run and the next keep offering beats.
      if (run == 3) hold_req = 1'b1;
      if (run != 3 && run != 4 && $urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       len = '0;
          1:       len = LEN_W'(1);
          2:       len = LEN_W'(MAX_TOP);
          3:       len = '1;
          default: len = LEN_W'($urandom_range(2, 20));
        endcase
        write_len(len);
      end
      run_items = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int k = 1; k <= run_items; k++) begin
        if (run > 4 && k > 1 && $urandom_range(0, 19) == 0)
          write_len(LEN_W'($urandom_range(0, 31)));
        case ($urandom_range(0, 3))
          0:       f = FREQ_W'($urandom());
          1:       f = FREQ_W'($urandom_range(0, 7));
          2:       f = ($urandom_range(0, 1) != 0) ? '1 : '0;
          default: f = FREQ_W'($urandom_range(0, 255));
        endcase
        offer(f, TAG_W'($urandom()), k == run_items, 1'b0, '0, '0);
        sent++;
      end
      run++;
    end

    settle();
    if (errors == 0)
      $display("top_n_frequency_select_test OK");
    else
      $display("top_n_frequency_select_test NOT OK");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("top_n_frequency_select_test NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tnfs_pkg.sv
hw/rtl/tnfs_cell.sv
hw/rtl/top_n_frequency_select.sv
tb/sv/top_n_frequency_select_test.sv
